### rtl/core/cst_pkg.sv
// Package for the cardinal spline tessellator.
// Holds sizes, opcode codes and the structs used by the front, back and top level.
// No dependencies.
package cst_pkg;

   // Point store geometry.
   localparam int MAX_POINTS = 256;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // Coordinate and point widths.
   localparam int COORD_W = 24;
   localparam int POINT_W = 2 * COORD_W;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = -24'sh800000;

   // Samples per segment register.
   localparam int SL_W = 3;
   localparam logic [SL_W-1:0] SL_RESET = 3'd6;
   localparam logic [SL_W-1:0] SL_MAX   = 3'd6;
   localparam int K_W = 6;

   // Arithmetic widths of the sample evaluation.
   localparam int D_W    = COORD_W + 1;
   localparam int CA_W   = COORD_W + 4;
   localparam int CB_W   = COORD_W + 5;
   localparam int KSQ_W  = 2 * K_W;
   localparam int KCU_W  = 3 * K_W;
   localparam int MA_W   = CA_W + KCU_W + 1;
   localparam int MB_W   = CB_W + KSQ_W + 1;
   localparam int MC_W   = D_W + K_W + 1;
   localparam int SUM_W  = 52;
   localparam int SH_W   = 5;

   // Fetch sequence: four reads, the last read data lands in the following cycle.
   localparam logic [2:0] FETCH_LAST = 3'd4;

   // Command queue between front and back.
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = 1;
   localparam int CMD_CNT_W = 2;

   // Result queue in the back part.
   localparam int OUT_DEPTH = 8;
   localparam int OUT_PTR_W = 3;
   localparam int OUT_CNT_W = 4;

   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_APPEND = 2'd1,
      OP_EMIT   = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   // One segment to tessellate: the four store indexes, tangent flags and curve end flag.
   typedef struct packed {
      logic [IDX_W-1:0] idx_prev;
      logic [IDX_W-1:0] idx_a;
      logic [IDX_W-1:0] idx_b;
      logic [IDX_W-1:0] idx_next;
      logic             d0_zero;
      logic             d1_zero;
      logic             curve_last;
   } cmd_type;

   // Back part status seen by the front part.
   typedef struct packed {
      logic busy;
      logic queue_empty;
   } status_type;

   // One result item.
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               seg_end;
      logic               crv_end;
   } out_type;

endpackage

### rtl/core/cardinal_spline_tessellator_top.sv
// Cardinal spline tessellator top level. Append items are always accepted; a start item
// waits until the back part is idle and no segment command is queued.
// An emit item with a segment left yields 2^samples_log2 items: after the command is
// taken, the back part fetches four points from the store, forms the tangent
// differences and then the coefficients, and runs a five-stage evaluation; items
// then follow one per cycle while the receiver keeps up.
// Reset clears the curve state, queues and register (samples_log2 = 6); the
// point store is not cleared and needs no clearing pass.
module cardinal_spline_tessellator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_opcode,
   input  logic signed [cst_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [cst_pkg::COORD_W-1:0] req_point_y,
   input  logic                          req_closed,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [cst_pkg::COORD_W-1:0] rsp_sample_x,
   output logic signed [cst_pkg::COORD_W-1:0] rsp_sample_y,
   output logic                          rsp_segment_end,
   output logic                          rsp_curve_end,
   input  logic                          csr_write_en,
   input  logic [cst_pkg::SL_W-1:0]      csr_write_data
);
   import cst_pkg::*;

   logic [SL_W-1:0]    samples_log2_ff;
   logic [SL_W-1:0]    samples_log2;
   status_type         status;
   logic               back_busy;
   logic               cmd_full, cmd_empty, cmd_push, cmd_pop;
   cmd_type            cmd_wr, cmd_rd;
   logic               ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]   ram_wr_addr, ram_rd_addr;
   logic [POINT_W-1:0] ram_wr_data, ram_rd_data;

   // Samples per segment register; codes above the range act as the maximum.
   always_ff @(posedge clock) begin
      if (reset) begin
         samples_log2_ff <= SL_RESET;
      end else if (csr_write_en) begin
         samples_log2_ff <= csr_write_data;
      end
   end

   assign samples_log2       = (samples_log2_ff > SL_MAX) ? SL_MAX : samples_log2_ff;
   assign status.busy        = back_busy;
   assign status.queue_empty = cmd_empty;

   cst_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_opcode  (req_opcode),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_closed  (req_closed),
      .status      (status),
      .cmd_full    (cmd_full),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_wr),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   cst_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .data_in  (cmd_wr),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .data_out (cmd_rd),
      .empty    (cmd_empty)
   );

   cst_ram #(
      .WIDTH (POINT_W),
      .DEPTH (MAX_POINTS)
   ) u_point_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cst_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_empty       (cmd_empty),
      .cmd_data        (cmd_rd),
      .cmd_pop         (cmd_pop),
      .samples_log2    (samples_log2),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .busy            (back_busy),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_sample_x    (rsp_sample_x),
      .rsp_sample_y    (rsp_sample_y),
      .rsp_segment_end (rsp_segment_end),
      .rsp_curve_end   (rsp_curve_end)
   );
endmodule

### rtl/core/cst_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module cst_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/core/cst_front.sv
// Front part: accepts input items, writes points into the store and turns
// emit items into segment commands. Depends on cst_pkg.
module cst_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_opcode,
   input  logic signed [cst_pkg::COORD_W-1:0] req_point_x,
   input  logic signed [cst_pkg::COORD_W-1:0] req_point_y,
   input  logic                          req_closed,
   input  cst_pkg::status_type           status,
   input  logic                          cmd_full,
   output logic                          cmd_push,
   output cst_pkg::cmd_type              cmd_data,
   output logic                          ram_wr_en,
   output logic [cst_pkg::IDX_W-1:0]     ram_wr_addr,
   output logic [cst_pkg::POINT_W-1:0]   ram_wr_data
);
   import cst_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] next_ff, next_in;
   logic             closed_ff, closed_in;
   logic [CNT_W-1:0] segs, a_inc, b_ext, b_inc, bp1_ext, cnt_dec, a_dec;
   logic             accept, has_seg;
   opcode_type       op;

   assign op = opcode_type'(req_opcode);

   // Segment geometry of the next emit.
   always_comb begin
      if (closed_ff) begin
         segs = count_ff;
      end else if (count_ff >= CNT_W'(2)) begin
         segs = count_ff - CNT_W'(1);
      end else begin
         segs = '0;
      end
      has_seg = next_ff < segs;
      a_inc   = next_ff + CNT_W'(1);
      b_ext   = (a_inc >= count_ff) ? '0 : a_inc;
      b_inc   = b_ext + CNT_W'(1);
      bp1_ext = (b_inc >= count_ff) ? '0 : b_inc;
      cnt_dec = count_ff - CNT_W'(1);
      a_dec   = next_ff - CNT_W'(1);
      cmd_data.idx_a      = next_ff[IDX_W-1:0];
      cmd_data.idx_b      = b_ext[IDX_W-1:0];
      cmd_data.idx_next   = bp1_ext[IDX_W-1:0];
      cmd_data.idx_prev   = (next_ff == '0) ? cnt_dec[IDX_W-1:0] : a_dec[IDX_W-1:0];
      cmd_data.d0_zero    = !closed_ff && (next_ff == '0);
      cmd_data.d1_zero    = !closed_ff && (b_inc >= count_ff);
      cmd_data.curve_last = a_inc == segs;
   end

   // A start waits until the back part no longer reads the store.
   always_comb begin
      case (op)
         OP_START: req_full = status.busy || !status.queue_empty;
         OP_EMIT:  req_full = cmd_full;
         default:  req_full = 1'b0;
      endcase
   end

   assign accept      = req_push && !req_full;
   assign ram_wr_data = {req_point_x, req_point_y};

   // Classify the item and update the curve state.
   always_comb begin
      count_in    = count_ff;
      next_in     = next_ff;
      closed_in   = closed_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      cmd_push    = 1'b0;
      if (accept) begin
         case (op)
            OP_START: begin
               ram_wr_en = 1'b1;
               count_in  = CNT_W'(1);
               next_in   = '0;
               closed_in = req_closed;
            end
            OP_APPEND: begin
               if (count_ff < CNT_W'(MAX_POINTS)) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = count_ff[IDX_W-1:0];
                  count_in    = count_ff + CNT_W'(1);
               end
            end
            OP_EMIT: begin
               if (has_seg) begin
                  cmd_push = 1'b1;
                  next_in  = a_inc;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         next_ff   <= '0;
         closed_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         next_ff   <= next_in;
         closed_ff <= closed_in;
      end
   end
endmodule

### rtl/core/cst_cmd_fifo.sv
// Short queue of segment commands between the front and back parts.
// Depends on cst_pkg.
module cst_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cst_pkg::cmd_type data_in,
   output logic             full,
   input  logic             pop,
   output cst_pkg::cmd_type data_out,
   output logic             empty
);
   import cst_pkg::*;

   cmd_type              entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CMD_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign full     = cnt_ff == CMD_CNT_W'(CMD_DEPTH);
   assign empty    = cnt_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign data_out = entry_ff[rd_ptr_ff];
   assign cnt_in   = cnt_ff + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + CMD_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + CMD_PTR_W'(1);
         end
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= data_in;
      end
   end
endmodule

### rtl/core/cst_back.sv
// Back part: fetches the four points of a segment, forms the cubic
// coefficients and evaluates samples in a pipeline into a result queue.
// Depends on cst_pkg.
module cst_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_empty,
   input  cst_pkg::cmd_type              cmd_data,
   output logic                          cmd_pop,
   input  logic [cst_pkg::SL_W-1:0]      samples_log2,
   output logic                          ram_rd_en,
   output logic [cst_pkg::IDX_W-1:0]     ram_rd_addr,
   input  logic [cst_pkg::POINT_W-1:0]   ram_rd_data,
   output logic                          busy,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [cst_pkg::COORD_W-1:0] rsp_sample_x,
   output logic signed [cst_pkg::COORD_W-1:0] rsp_sample_y,
   output logic                          rsp_segment_end,
   output logic                          rsp_curve_end
);
   import cst_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIFF,
      ST_COEF,
      ST_RUN
   } state_type;

   state_type            state_ff, state_in;
   logic [2:0]           fetch_ff, fetch_in;
   cmd_type              cmd_ff, cmd_in;
   logic [K_W-1:0]       k_ff, k_in;
   logic [OUT_CNT_W-1:0] used_ff, used_in;

   // Segment points and coefficients, index 0 is x and 1 is y.
   logic signed [COORD_W-1:0] pm_ff [2];
   logic signed [COORD_W-1:0] p0_ff [2];
   logic signed [COORD_W-1:0] p1_ff [2];
   logic signed [COORD_W-1:0] pp_ff [2];
   logic signed [D_W-1:0]     d0_ff [2];
   logic signed [D_W-1:0]     d1_ff [2];
   logic signed [CA_W-1:0]    ca_ff [2];
   logic signed [CB_W-1:0]    cb_ff [2];
   logic signed [D_W-1:0]     cd0_ff [2];
   logic signed [COORD_W-1:0] cp0_ff [2];
   logic signed [D_W-1:0]     d0_calc [2];
   logic signed [D_W-1:0]     d1_calc [2];
   logic signed [CA_W-1:0]    ca_calc [2];
   logic signed [CB_W-1:0]    cb_calc [2];
   logic signed [COORD_W-1:0] rd_coord [2];

   // Sample pipeline.
   logic                      s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic                      s1_seg_ff, s2_seg_ff, s3_seg_ff, s4_seg_ff, s5_seg_ff;
   logic                      s1_crv_ff, s2_crv_ff, s3_crv_ff, s4_crv_ff, s5_crv_ff;
   logic [K_W-1:0]            s1_k_ff, s2_k_ff, s3_k_ff;
   logic [KSQ_W-1:0]          s2_ksq_ff, s3_ksq_ff;
   logic [KCU_W-1:0]          s3_kcu_ff;
   logic signed [MA_W-1:0]    s4_ma_ff [2];
   logic signed [MB_W-1:0]    s4_mb_ff [2];
   logic signed [MC_W-1:0]    s4_mc_ff [2];
   logic signed [SUM_W-1:0]   s5_sum_ff [2];
   logic signed [SUM_W-1:0]   sum_calc [2];
   logic signed [SUM_W-1:0]   shr_calc [2];
   logic signed [COORD_W-1:0] sat_calc [2];
   logic signed [SUM_W-1:0]   half;

   // Result queue.
   out_type              out_mem_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] out_wr_ff, out_rd_ff;
   logic [OUT_CNT_W-1:0] out_cnt_ff;
   out_type              out_head, out_new;

   logic [K_W:0]   one_s;
   logic [K_W:0]   kmax_full;
   logic [K_W-1:0] kmax;
   logic [SH_W-1:0] sh2, sh3, sh_half;
   logic           issue, k_last, pop_out;

   // Sample count and shift amounts for the current register value.
   always_comb begin
      one_s     = (K_W+1)'(1) << samples_log2;
      kmax_full = one_s - (K_W+1)'(1);
      kmax      = kmax_full[K_W-1:0];
      sh2       = SH_W'(samples_log2) << 1;
      sh_half   = SH_W'(samples_log2) * SH_W'(3);
      sh3       = sh_half + SH_W'(1);
      half      = SUM_W'(1) <<< sh_half;
   end

   assign issue   = (state_ff == ST_RUN) && (used_ff < OUT_CNT_W'(OUT_DEPTH));
   assign k_last  = k_ff == kmax;
   assign pop_out = rsp_pop && !rsp_empty;
   assign used_in = used_ff + OUT_CNT_W'(issue) - OUT_CNT_W'(pop_out);
   assign cmd_pop = (state_ff == ST_IDLE) && !cmd_empty;
   assign busy    = state_ff != ST_IDLE;

   // Store reads of the fetch sequence.
   always_comb begin
      ram_rd_en = (state_ff == ST_FETCH) && (fetch_ff < FETCH_LAST);
      case (fetch_ff)
         3'd0:    ram_rd_addr = cmd_ff.idx_prev;
         3'd1:    ram_rd_addr = cmd_ff.idx_a;
         3'd2:    ram_rd_addr = cmd_ff.idx_b;
         default: ram_rd_addr = cmd_ff.idx_next;
      endcase
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      fetch_in = fetch_ff;
      cmd_in   = cmd_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               state_in = ST_FETCH;
               fetch_in = '0;
               cmd_in   = cmd_data;
            end
         end
         ST_FETCH: begin
            fetch_in = fetch_ff + 3'd1;
            if (fetch_ff == FETCH_LAST) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: state_in = ST_COEF;
         ST_COEF: begin
            state_in = ST_RUN;
            k_in     = '0;
         end
         ST_RUN: begin
            if (issue) begin
               k_in = k_ff + K_W'(1);
               if (k_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fetch_ff <= '0;
         k_ff     <= '0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fetch_ff <= fetch_in;
         k_ff     <= k_in;
         used_ff  <= used_in;
      end
      cmd_ff <= cmd_in;
   end

   // Tangent differences and cubic coefficients.
   always_comb begin
      rd_coord[0] = ram_rd_data[POINT_W-1:COORD_W];
      rd_coord[1] = ram_rd_data[COORD_W-1:0];
      for (int i = 0; i < 2; i++) begin
         d0_calc[i] = cmd_ff.d0_zero ? '0 : D_W'(p1_ff[i]) - D_W'(pm_ff[i]);
         d1_calc[i] = cmd_ff.d1_zero ? '0 : D_W'(pp_ff[i]) - D_W'(p0_ff[i]);
         ca_calc[i] = (CA_W'(p0_ff[i]) <<< 2) - (CA_W'(p1_ff[i]) <<< 2)
                    + CA_W'(d0_ff[i]) + CA_W'(d1_ff[i]);
         cb_calc[i] = CB_W'(p1_ff[i]) * CB_W'(6) - CB_W'(p0_ff[i]) * CB_W'(6)
                    - (CB_W'(d0_ff[i]) <<< 1) - CB_W'(d1_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         if (state_ff == ST_FETCH) begin
            case (fetch_ff)
               3'd1:    pm_ff[i] <= rd_coord[i];
               3'd2:    p0_ff[i] <= rd_coord[i];
               3'd3:    p1_ff[i] <= rd_coord[i];
               3'd4:    pp_ff[i] <= rd_coord[i];
               default: begin
               end
            endcase
         end
         if (state_ff == ST_DIFF) begin
            d0_ff[i] <= d0_calc[i];
            d1_ff[i] <= d1_calc[i];
         end
         if (state_ff == ST_COEF) begin
            ca_ff[i]  <= ca_calc[i];
            cb_ff[i]  <= cb_calc[i];
            cd0_ff[i] <= d0_ff[i];
            cp0_ff[i] <= p0_ff[i];
         end
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // Sum of the shifted terms with the rounding half, then the final shift and saturation.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         sum_calc[i] = SUM_W'(s4_ma_ff[i]) + (SUM_W'(s4_mb_ff[i]) <<< samples_log2)
                     + (SUM_W'(s4_mc_ff[i]) <<< sh2) + (SUM_W'(cp0_ff[i]) <<< sh3) + half;
         shr_calc[i] = s5_sum_ff[i] >>> sh3;
         if (shr_calc[i] > SUM_W'(COORD_MAX)) begin
            sat_calc[i] = COORD_MAX;
         end else if (shr_calc[i] < SUM_W'(COORD_MIN)) begin
            sat_calc[i] = COORD_MIN;
         end else begin
            sat_calc[i] = shr_calc[i][COORD_W-1:0];
         end
      end
   end

   // Powers of k, products, sum.
   always_ff @(posedge clock) begin
      s1_k_ff   <= k_ff;
      s1_seg_ff <= k_last;
      s1_crv_ff <= k_last && cmd_ff.curve_last;
      s2_k_ff   <= s1_k_ff;
      s2_ksq_ff <= KSQ_W'(s1_k_ff * s1_k_ff);
      s2_seg_ff <= s1_seg_ff;
      s2_crv_ff <= s1_crv_ff;
      s3_k_ff   <= s2_k_ff;
      s3_ksq_ff <= s2_ksq_ff;
      s3_kcu_ff <= KCU_W'(s2_ksq_ff * KCU_W'(s2_k_ff));
      s3_seg_ff <= s2_seg_ff;
      s3_crv_ff <= s2_crv_ff;
      s4_seg_ff <= s3_seg_ff;
      s4_crv_ff <= s3_crv_ff;
      s5_seg_ff <= s4_seg_ff;
      s5_crv_ff <= s4_crv_ff;
      for (int i = 0; i < 2; i++) begin
         s4_ma_ff[i]  <= ca_ff[i] * $signed({1'b0, s3_kcu_ff});
         s4_mb_ff[i]  <= cb_ff[i] * $signed({1'b0, s3_ksq_ff});
         s4_mc_ff[i]  <= cd0_ff[i] * $signed({1'b0, s3_k_ff});
         s5_sum_ff[i] <= sum_calc[i];
      end
   end

   // Result queue; the issue credit keeps it from overflowing.
   always_comb begin
      out_new.x       = sat_calc[0];
      out_new.y       = sat_calc[1];
      out_new.seg_end = s5_seg_ff;
      out_new.crv_end = s5_crv_ff;
      out_head        = out_mem_ff[out_rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         if (s5_valid_ff) begin
            out_wr_ff <= out_wr_ff + OUT_PTR_W'(1);
         end
         if (pop_out) begin
            out_rd_ff <= out_rd_ff + OUT_PTR_W'(1);
         end
         out_cnt_ff <= out_cnt_ff + OUT_CNT_W'(s5_valid_ff) - OUT_CNT_W'(pop_out);
      end
   end

   always_ff @(posedge clock) begin
      if (s5_valid_ff) begin
         out_mem_ff[out_wr_ff] <= out_new;
      end
   end

   assign rsp_empty       = out_cnt_ff == '0;
   assign rsp_sample_x    = out_head.x;
   assign rsp_sample_y    = out_head.y;
   assign rsp_segment_end = out_head.seg_end;
   assign rsp_curve_end   = out_head.crv_end;
endmodule
